/* design/r2k_pkg.sv */
// Shared types, constants and lookup tables for the romaji to katakana converter.
package r2k_pkg;

   localparam int unsigned CharWidth   = 8;
   localparam int unsigned StateWidth  = 6;
   localparam int unsigned NumStates   = 56;
   localparam int unsigned NumSingle   = 21;
   localparam int unsigned QueueDepth  = 2;

   localparam logic [7:0] SMALL_TSU = 8'hAF;
   localparam logic [7:0] KANA_N    = 8'hDD;

   localparam logic [5:0] CODE_H = 6'd6;
   localparam logic [5:0] CODE_N = 6'd11;
   localparam logic [5:0] CODE_T = 6'd16;
   localparam logic [5:0] CODE_W = 6'd18;
   localparam logic [5:0] CODE_Y = 6'd20;

   typedef enum logic [1:0] {
      STATUS_PENDING  = 2'd0,
      STATUS_COMPLETE = 2'd1,
      STATUS_REJECT   = 2'd2
   } status_type;

   // A classified word handed from the front part to the back part.
   typedef struct packed {
      status_type  status;
      logic [1:0]  count;   // number of bytes minus one when has_bytes
      logic        has_bytes;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [7:0]  byte3;
   } job_type;

   // Kana string of up to three bytes, first byte in the top bits.
   function automatic logic [23:0] kana_lookup(input logic [5:0] st, input logic [2:0] v);
      logic [23:0] r;
      r = 24'h0;
      case ({st, v})
         {6'd0,3'd0}: r=24'hb10000; {6'd0,3'd1}: r=24'hb40000; {6'd0,3'd2}: r=24'hb20000;
         {6'd0,3'd3}: r=24'hb50000; {6'd0,3'd4}: r=24'hb30000;
         {6'd1,3'd0}: r=24'hcade00; {6'd1,3'd1}: r=24'hcdde00; {6'd1,3'd2}: r=24'hcbde00;
         {6'd1,3'd3}: r=24'hcede00; {6'd1,3'd4}: r=24'hccde00;
         {6'd2,3'd0}: r=24'hb60000; {6'd2,3'd1}: r=24'hbe0000; {6'd2,3'd2}: r=24'hbc0000;
         {6'd2,3'd3}: r=24'hba0000; {6'd2,3'd4}: r=24'hb80000;
         {6'd3,3'd0}: r=24'hc0de00; {6'd3,3'd1}: r=24'hc3de00; {6'd3,3'd2}: r=24'hc1de00;
         {6'd3,3'd3}: r=24'hc4de00; {6'd3,3'd4}: r=24'hc2de00;
         {6'd4,3'd0}: r=24'hcca700; {6'd4,3'd1}: r=24'hccaa00; {6'd4,3'd2}: r=24'hcca800;
         {6'd4,3'd3}: r=24'hccab00; {6'd4,3'd4}: r=24'hcc0000;
         {6'd5,3'd0}: r=24'hb6de00; {6'd5,3'd1}: r=24'hb9de00; {6'd5,3'd2}: r=24'hb7de00;
         {6'd5,3'd3}: r=24'hbade00; {6'd5,3'd4}: r=24'hb8de00;
         {6'd6,3'd0}: r=24'hca0000; {6'd6,3'd1}: r=24'hcd0000; {6'd6,3'd2}: r=24'hcb0000;
         {6'd6,3'd3}: r=24'hce0000; {6'd6,3'd4}: r=24'hcc0000;
         {6'd7,3'd0}: r=24'hbcdeac; {6'd7,3'd1}: r=24'hbcdeaa; {6'd7,3'd2}: r=24'hbcde00;
         {6'd7,3'd3}: r=24'hbcdeae; {6'd7,3'd4}: r=24'hbcdead;
         {6'd8,3'd0}: r=24'hb60000; {6'd8,3'd1}: r=24'hb90000; {6'd8,3'd2}: r=24'hb70000;
         {6'd8,3'd3}: r=24'hba0000; {6'd8,3'd4}: r=24'hb80000;
         {6'd9,3'd0}: r=24'ha70000; {6'd9,3'd1}: r=24'haa0000; {6'd9,3'd2}: r=24'ha80000;
         {6'd9,3'd3}: r=24'hab0000; {6'd9,3'd4}: r=24'ha90000;
         {6'd10,3'd0}: r=24'hcf0000; {6'd10,3'd1}: r=24'hd20000; {6'd10,3'd2}: r=24'hd00000;
         {6'd10,3'd3}: r=24'hd30000; {6'd10,3'd4}: r=24'hd10000;
         {6'd11,3'd0}: r=24'hc50000; {6'd11,3'd1}: r=24'hc80000; {6'd11,3'd2}: r=24'hc60000;
         {6'd11,3'd3}: r=24'hc90000; {6'd11,3'd4}: r=24'hc70000;
         {6'd12,3'd0}: r=24'hcadf00; {6'd12,3'd1}: r=24'hcddf00; {6'd12,3'd2}: r=24'hcbdf00;
         {6'd12,3'd3}: r=24'hcedf00; {6'd12,3'd4}: r=24'hccdf00;
         {6'd13,3'd0}: r=24'hb8a700; {6'd13,3'd1}: r=24'hb8aa00; {6'd13,3'd2}: r=24'hb8a800;
         {6'd13,3'd3}: r=24'hb8ab00; {6'd13,3'd4}: r=24'hb80000;
         {6'd14,3'd0}: r=24'hd70000; {6'd14,3'd1}: r=24'hda0000; {6'd14,3'd2}: r=24'hd80000;
         {6'd14,3'd3}: r=24'hdb0000; {6'd14,3'd4}: r=24'hd90000;
         {6'd15,3'd0}: r=24'hbb0000; {6'd15,3'd1}: r=24'hbe0000; {6'd15,3'd2}: r=24'hbc0000;
         {6'd15,3'd3}: r=24'hbf0000; {6'd15,3'd4}: r=24'hbd0000;
         {6'd16,3'd0}: r=24'hc00000; {6'd16,3'd1}: r=24'hc30000; {6'd16,3'd2}: r=24'hc10000;
         {6'd16,3'd3}: r=24'hc40000; {6'd16,3'd4}: r=24'hc20000;
         {6'd17,3'd0}: r=24'hb3dea7; {6'd17,3'd1}: r=24'hb3deaa; {6'd17,3'd2}: r=24'hb3dea8;
         {6'd17,3'd3}: r=24'hb3deab; {6'd17,3'd4}: r=24'hb3de00;
         {6'd18,3'd0}: r=24'hdc0000; {6'd18,3'd1}: r=24'hb3aa00; {6'd18,3'd2}: r=24'hb3a800;
         {6'd18,3'd3}: r=24'ha60000; {6'd18,3'd4}: r=24'hb30000;
         {6'd19,3'd0}: r=24'ha70000; {6'd19,3'd1}: r=24'haa0000; {6'd19,3'd2}: r=24'ha80000;
         {6'd19,3'd3}: r=24'hab0000; {6'd19,3'd4}: r=24'ha90000;
         {6'd20,3'd0}: r=24'hd40000; {6'd20,3'd1}: r=24'ha80000; {6'd20,3'd2}: r=24'hb20000;
         {6'd20,3'd3}: r=24'hd60000; {6'd20,3'd4}: r=24'hd50000;
         {6'd21,3'd0}: r=24'hbbde00; {6'd21,3'd1}: r=24'hbede00; {6'd21,3'd2}: r=24'hbcde00;
         {6'd21,3'd3}: r=24'hbfde00; {6'd21,3'd4}: r=24'hbdde00;
         {6'd22,3'd0}: r=24'hcbdeac; {6'd22,3'd1}: r=24'hcbdeaa; {6'd22,3'd2}: r=24'hcbdea8;
         {6'd22,3'd3}: r=24'hcbdeae; {6'd22,3'd4}: r=24'hcbdead;
         {6'd23,3'd0}: r=24'hc1ac00; {6'd23,3'd1}: r=24'hc1aa00; {6'd23,3'd2}: r=24'hc10000;
         {6'd23,3'd3}: r=24'hc1ae00; {6'd23,3'd4}: r=24'hc1ad00;
         {6'd24,3'd0}: r=24'hc1ac00; {6'd24,3'd1}: r=24'hc1aa00; {6'd24,3'd2}: r=24'hc1a800;
         {6'd24,3'd3}: r=24'hc1ae00; {6'd24,3'd4}: r=24'hc1ad00;
         {6'd25,3'd0}: r=24'hc3deac; {6'd25,3'd1}: r=24'hc3deaa; {6'd25,3'd2}: r=24'hc3dea8;
         {6'd25,3'd3}: r=24'hc3deae; {6'd25,3'd4}: r=24'hc3dead;
         {6'd26,3'd0}: r=24'hc4dea7; {6'd26,3'd1}: r=24'hc4deaa; {6'd26,3'd2}: r=24'hc4dea8;
         {6'd26,3'd3}: r=24'hc4deab; {6'd26,3'd4}: r=24'hc4dea9;
         {6'd27,3'd0}: r=24'hc1deac; {6'd27,3'd1}: r=24'hc1deaa; {6'd27,3'd2}: r=24'hc1dea8;
         {6'd27,3'd3}: r=24'hc1deae; {6'd27,3'd4}: r=24'hc1dead;
         {6'd28,3'd0}: r=24'hcca700; {6'd28,3'd1}: r=24'hccaa00; {6'd28,3'd2}: r=24'hcca800;
         {6'd28,3'd3}: r=24'hccab00; {6'd28,3'd4}: r=24'hcca900;
         {6'd29,3'd0}: r=24'hccac00; {6'd29,3'd1}: r=24'hccaa00; {6'd29,3'd2}: r=24'hcca800;
         {6'd29,3'd3}: r=24'hccae00; {6'd29,3'd4}: r=24'hccad00;
         {6'd30,3'd0}: r=24'hb8dea7; {6'd30,3'd1}: r=24'hb8deaa; {6'd30,3'd2}: r=24'hb8dea8;
         {6'd30,3'd3}: r=24'hb8deab; {6'd30,3'd4}: r=24'hb8dea9;
         {6'd31,3'd0}: r=24'hb7deac; {6'd31,3'd1}: r=24'hb7deaa; {6'd31,3'd2}: r=24'hb7dea8;
         {6'd31,3'd3}: r=24'hb7deae; {6'd31,3'd4}: r=24'hb7dead;
         {6'd32,3'd0}: r=24'hcbac00; {6'd32,3'd1}: r=24'hcbaa00; {6'd32,3'd2}: r=24'hcba800;
         {6'd32,3'd3}: r=24'hcbae00; {6'd32,3'd4}: r=24'hcbad00;
         {6'd33,3'd0}: r=24'hbcdeac; {6'd33,3'd1}: r=24'hbcdeaa; {6'd33,3'd2}: r=24'hbcdea8;
         {6'd33,3'd3}: r=24'hbcdeae; {6'd33,3'd4}: r=24'hbcdead;
         {6'd34,3'd0}: r=24'hb8a700;
         {6'd35,3'd0}: r=24'hb7ac00; {6'd35,3'd1}: r=24'hb7aa00; {6'd35,3'd2}: r=24'hb7a800;
         {6'd35,3'd3}: r=24'hb7ae00; {6'd35,3'd4}: r=24'hb7ad00;
         {6'd36,3'd4}: r=24'haf0000;
         {6'd37,3'd0}: r=24'hac0000; {6'd37,3'd1}: r=24'haa0000; {6'd37,3'd2}: r=24'ha80000;
         {6'd37,3'd3}: r=24'hae0000; {6'd37,3'd4}: r=24'had0000;
         {6'd38,3'd0}: r=24'hd0ac00; {6'd38,3'd1}: r=24'hd0aa00; {6'd38,3'd2}: r=24'hd0a800;
         {6'd38,3'd3}: r=24'hd0ae00; {6'd38,3'd4}: r=24'hd0ad00;
         {6'd39,3'd0}: r=24'hc6ac00; {6'd39,3'd1}: r=24'hc6aa00; {6'd39,3'd2}: r=24'hc6a800;
         {6'd39,3'd3}: r=24'hc6ae00; {6'd39,3'd4}: r=24'hc6ad00;
         {6'd40,3'd0}: r=24'hcbdfac; {6'd40,3'd1}: r=24'hcbdfaa; {6'd40,3'd2}: r=24'hcbdfa8;
         {6'd40,3'd3}: r=24'hcbdfae; {6'd40,3'd4}: r=24'hcbdfad;
         {6'd41,3'd0}: r=24'hb8a700; {6'd41,3'd1}: r=24'hb8aa00; {6'd41,3'd2}: r=24'hb8a800;
         {6'd41,3'd3}: r=24'hb8ab00; {6'd41,3'd4}: r=24'hb8a900;
         {6'd42,3'd0}: r=24'hb8ac00; {6'd42,3'd1}: r=24'hb8aa00; {6'd42,3'd2}: r=24'hb8a800;
         {6'd42,3'd3}: r=24'hb8ae00; {6'd42,3'd4}: r=24'hb8ad00;
         {6'd43,3'd0}: r=24'hd8ac00; {6'd43,3'd1}: r=24'hd8aa00; {6'd43,3'd2}: r=24'hd8a800;
         {6'd43,3'd3}: r=24'hd8ae00; {6'd43,3'd4}: r=24'hd8ad00;
         {6'd44,3'd0}: r=24'hbcac00; {6'd44,3'd1}: r=24'hbcaa00; {6'd44,3'd2}: r=24'hbc0000;
         {6'd44,3'd3}: r=24'hbcae00; {6'd44,3'd4}: r=24'hbcad00;
         {6'd45,3'd0}: r=24'hbda700; {6'd45,3'd1}: r=24'hbdaa00; {6'd45,3'd2}: r=24'hbda800;
         {6'd45,3'd3}: r=24'hbdab00; {6'd45,3'd4}: r=24'hbda900;
         {6'd46,3'd0}: r=24'hbcac00; {6'd46,3'd1}: r=24'hbcaa00; {6'd46,3'd2}: r=24'hbca800;
         {6'd46,3'd3}: r=24'hbcae00; {6'd46,3'd4}: r=24'hbcad00;
         {6'd47,3'd0}: r=24'hc3ac00; {6'd47,3'd1}: r=24'hc3aa00; {6'd47,3'd2}: r=24'hc3a800;
         {6'd47,3'd3}: r=24'hc3ae00; {6'd47,3'd4}: r=24'hc3ad00;
         {6'd48,3'd0}: r=24'hc2a700; {6'd48,3'd1}: r=24'hc2aa00; {6'd48,3'd2}: r=24'hc2a800;
         {6'd48,3'd3}: r=24'hc2ab00; {6'd48,3'd4}: r=24'hc20000;
         {6'd49,3'd0}: r=24'hc4a700; {6'd49,3'd1}: r=24'hc4aa00; {6'd49,3'd2}: r=24'hc4a800;
         {6'd49,3'd3}: r=24'hc4ab00; {6'd49,3'd4}: r=24'hc4a900;
         {6'd50,3'd0}: r=24'hc1ac00; {6'd50,3'd1}: r=24'hc1aa00; {6'd50,3'd2}: r=24'hc1a800;
         {6'd50,3'd3}: r=24'hc1ae00; {6'd50,3'd4}: r=24'hc1ad00;
         {6'd51,3'd0}: r=24'hb3deac; {6'd51,3'd1}: r=24'hb3deaa; {6'd51,3'd2}: r=24'hb3dea8;
         {6'd51,3'd3}: r=24'hb3deae; {6'd51,3'd4}: r=24'hb3dead;
         {6'd52,3'd0}: r=24'hb3a700; {6'd52,3'd1}: r=24'hb3aa00; {6'd52,3'd2}: r=24'hb3a800;
         {6'd52,3'd3}: r=24'hb3ab00; {6'd52,3'd4}: r=24'hb30000;
         {6'd53,3'd4}: r=24'haf0000;
         {6'd54,3'd0}: r=24'hac0000; {6'd54,3'd1}: r=24'haa0000; {6'd54,3'd2}: r=24'haa0000;
         {6'd54,3'd3}: r=24'hae0000; {6'd54,3'd4}: r=24'had0000;
         {6'd55,3'd0}: r=24'hbcdeac; {6'd55,3'd1}: r=24'hbcdeaa; {6'd55,3'd2}: r=24'hbcdea8;
         {6'd55,3'd3}: r=24'hbcdeae; {6'd55,3'd4}: r=24'hbcdead;
         default: r = 24'h0;
      endcase
      return r;
   endfunction

   // Letter class: bit 7 marks a vowel with its index in the low bits.
   function automatic logic [7:0] letter_code(input logic [4:0] idx);
      logic [7:0] r;
      case (idx)
         5'd0: r = 8'h80;  5'd1: r = 8'd1;   5'd2: r = 8'd2;   5'd3: r = 8'd3;
         5'd4: r = 8'h81;  5'd5: r = 8'd4;   5'd6: r = 8'd5;   5'd7: r = 8'd6;
         5'd8: r = 8'h82;  5'd9: r = 8'd7;   5'd10: r = 8'd8;  5'd11: r = 8'd9;
         5'd12: r = 8'd10; 5'd13: r = 8'd11; 5'd14: r = 8'h83; 5'd15: r = 8'd12;
         5'd16: r = 8'd13; 5'd17: r = 8'd14; 5'd18: r = 8'd15; 5'd19: r = 8'd16;
         5'd20: r = 8'h84; 5'd21: r = 8'd17; 5'd22: r = 8'd18; 5'd23: r = 8'd19;
         5'd24: r = 8'd20; 5'd25: r = 8'd21;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   // Two-letter move for a second consonant; zero means none.
   function automatic logic [5:0] two_letter_move(input logic [5:0] st, input logic [5:0] code);
      logic [5:0] r;
      r = 6'd0;
      case (code)
         CODE_H: case (st)
            6'd2: r = 6'd23; 6'd3: r = 6'd25; 6'd15: r = 6'd44; 6'd16: r = 6'd47;
            6'd18: r = 6'd52; default: r = 6'd0;
         endcase
         CODE_W: case (st)
            6'd3: r = 6'd26; 6'd4: r = 6'd28; 6'd5: r = 6'd30; 6'd8: r = 6'd34;
            6'd13: r = 6'd41; 6'd15: r = 6'd45; 6'd16: r = 6'd49; default: r = 6'd0;
         endcase
         CODE_T: case (st)
            6'd9: r = 6'd36; 6'd19: r = 6'd53; default: r = 6'd0;
         endcase
         CODE_Y: case (st)
            6'd1: r = 6'd22;  6'd2: r = 6'd24;  6'd3: r = 6'd27;  6'd4: r = 6'd29;
            6'd5: r = 6'd31;  6'd6: r = 6'd32;  6'd7: r = 6'd33;  6'd8: r = 6'd35;
            6'd9: r = 6'd37;  6'd10: r = 6'd38; 6'd11: r = 6'd39; 6'd12: r = 6'd40;
            6'd13: r = 6'd42; 6'd14: r = 6'd43; 6'd15: r = 6'd46; 6'd16: r = 6'd50;
            6'd17: r = 6'd51; 6'd19: r = 6'd54; 6'd21: r = 6'd55; default: r = 6'd0;
         endcase
         default: r = 6'd0;
      endcase
      return r;
   endfunction

endpackage

/* design/r2k_front.sv */
// Front part: classifies each character, advances the consonant state and builds a job word.
module r2k_front
   import r2k_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [CharWidth-1:0] char_code,
   output job_type              job
);

   logic [StateWidth-1:0] state_ff, state_in;
   logic                  tsu_ff, tsu_in;

   logic [7:0]  lower;
   logic [7:0]  code;
   logic [5:0]  cons;
   logic [5:0]  nxt;
   logic [23:0] kana;
   logic        is_letter;

   always_comb begin
      lower = char_code;
      if (char_code inside {[8'h41:8'h5A]}) begin
         lower = char_code + 8'h20;
      end
      is_letter = lower inside {[8'h61:8'h7A]};
      code = letter_code(5'(lower - 8'h61));
      cons = code[5:0];
      nxt  = two_letter_move(state_ff, cons);
      kana = kana_lookup(state_ff, code[2:0]);

      state_in = state_ff;
      tsu_in   = tsu_ff;
      job = '0;
      job.status = STATUS_PENDING;

      if (!is_letter) begin
         job.status = STATUS_REJECT;
         state_in = '0;
         tsu_in = 1'b0;
      end else if (code[7]) begin
         state_in = '0;
         tsu_in = 1'b0;
         if (state_ff >= StateWidth'(NumStates)) begin
            job.status = STATUS_REJECT;
         end else begin
            job.status = STATUS_COMPLETE;
            // Pack the small tsu, if any, ahead of the kana string.
            if (tsu_ff) begin
               job.byte0 = SMALL_TSU;
               job.byte1 = kana[23:16];
               job.byte2 = kana[15:8];
               job.byte3 = kana[7:0];
               job.has_bytes = 1'b1;
               job.count = (kana[23:16] == 8'h0) ? 2'd0 :
                           (kana[15:8] == 8'h0)  ? 2'd1 :
                           (kana[7:0] == 8'h0)   ? 2'd2 : 2'd3;
            end else begin
               job.byte0 = kana[23:16];
               job.byte1 = kana[15:8];
               job.byte2 = kana[7:0];
               job.has_bytes = kana[23:16] != 8'h0;
               job.count = (kana[15:8] == 8'h0) ? 2'd0 :
                           (kana[7:0] == 8'h0)  ? 2'd1 : 2'd2;
            end
         end
      end else if (state_ff == '0) begin
         state_in = cons;
      end else if (state_ff > StateWidth'(NumSingle)) begin
         // Consonant typed in a two-letter state is ignored.
      end else if (state_ff == cons) begin
         if (tsu_ff) begin
            job.status = STATUS_REJECT;
            state_in = '0;
            tsu_in = 1'b0;
         end else if (cons == CODE_N) begin
            job.status = STATUS_COMPLETE;
            job.byte0 = KANA_N;
            job.has_bytes = 1'b1;
            state_in = '0;
         end else begin
            tsu_in = 1'b1;
         end
      end else if (nxt == '0) begin
         job.status = STATUS_REJECT;
         state_in = '0;
         tsu_in = 1'b0;
      end else begin
         state_in = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         tsu_ff <= 1'b0;
      end else if (take) begin
         state_ff <= state_in;
         tsu_ff <= tsu_in;
      end
   end

endmodule

/* design/r2k_queue.sv */
// Short job queue between the front and back parts.
module r2k_queue
   import r2k_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type head_job
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   job_type               mem_ff [DEPTH];
   logic [PtrWidth-1:0]   rd_ff, wr_ff;
   logic [PtrWidth:0]     cnt_ff;

   assign full     = cnt_ff == (PtrWidth+1)'(DEPTH);
   assign empty    = cnt_ff == '0;
   assign head_job = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push && !full) begin
            wr_ff <= (wr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop && !empty) begin
            rd_ff <= (rd_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (PtrWidth+1)'(push && !full) - (PtrWidth+1)'(pop && !empty);
      end
   end

endmodule

/* design/r2k_back.sv */
// Back part: emits the bytes of one job word as result words, one per pop.
module r2k_back
   import r2k_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_empty,
   input  job_type    job,
   output logic       job_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_kana_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last
);

   logic [1:0] idx_ff;
   logic       is_last;

   assign rsp_empty = job_empty;
   assign is_last   = !job.has_bytes || (idx_ff == job.count);
   assign job_pop   = rsp_pop && !job_empty && is_last;

   always_comb begin
      rsp_status     = job.status;
      rsp_byte_valid = job.has_bytes;
      rsp_last       = is_last;
      case (idx_ff)
         2'd0: rsp_kana_byte = job.byte0;
         2'd1: rsp_kana_byte = job.byte1;
         2'd2: rsp_kana_byte = job.byte2;
         2'd3: rsp_kana_byte = job.byte3;
         default: rsp_kana_byte = job.byte0;
      endcase
      if (!job.has_bytes) begin
         rsp_kana_byte = 8'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (rsp_pop && !job_empty) begin
         idx_ff <= is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

endmodule

/* design/romaji_to_katakana_converter.sv */
// Top level of the romaji to half-width katakana converter.
// Each pushed word is one typed character. A front part folds case, classifies the
// letter, advances the consonant state and turns the outcome into one job word
// combinationally, so a character can be pushed on every cycle while the job queue has
// room. A back part takes jobs from the queue and presents one result word per byte:
// one word for a pending consonant or a rejection, and one to four words for a
// completed syllable (a leading small tsu, then up to three kana bytes). The rate is
// therefore set by the result side: an input needs as many pops as it has result
// words, one to four, and the queue of QUEUE_DEPTH jobs lets input keep flowing while
// earlier results drain. The last result word of each input carries rsp_last.
module romaji_to_katakana_converter
   import r2k_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [CharWidth-1:0] req_char_code,
   output logic                 empty,
   input  logic                 pop,
   output logic [1:0]           rsp_status,
   output logic [7:0]           rsp_kana_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_last
);

   job_type new_job;
   job_type head_job;
   logic    take;
   logic    job_empty;
   logic    job_pop;

   // The consonant state advances only when the character is really taken.
   assign take = push && !full;

   r2k_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_code (req_char_code),
      .job       (new_job)
   );

   r2k_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (new_job),
      .full     (full),
      .pop      (job_pop),
      .empty    (job_empty),
      .head_job (head_job)
   );

   r2k_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_empty      (job_empty),
      .job            (head_job),
      .job_pop        (job_pop),
      .rsp_empty      (empty),
      .rsp_pop        (pop),
      .rsp_status     (rsp_status),
      .rsp_kana_byte  (rsp_kana_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last)
   );

`ifndef ASSERT_OFF
   // A result word without a byte always ends its input.
   a_nobyte_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_byte_valid) |-> rsp_last)
      else $error("byte-less result word is not last");

   // Pending and rejected inputs never carry a byte.
   a_status_byte: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_status == STATUS_PENDING || rsp_status == STATUS_REJECT))
         |-> !rsp_byte_valid)
      else $error("byte on a pending or rejected result");

   // A word popped that is not last is followed by more of the same input.
   a_continue: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !rsp_last) |=> (!empty && rsp_byte_valid))
      else $error("result string broken off");
`endif

endmodule
